FILE: hdl/brf_pkg.sv
// Shared types, codes and default sizes for the byte ring FIFO.
// Used by every module of the block but the RAM; depends on nothing.
package brf_pkg;

	localparam int DEPTH_DEF   = 64;
	localparam int MAX_RUN_DEF = 64;

	localparam int REQ_W  = 2;
	localparam int DATA_W = 8;
	localparam int LEN_W  = 7;
	localparam int OCC_W  = 7;
	localparam int OP_W   = 2;

	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

	// internal command codes after classification
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [DATA_W-1:0] data_in;
		logic [LEN_W-1:0]  read_length;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic              data_valid;
		logic              accepted;
		logic              last_of_run;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
		logic              is_full;
	} rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage

FILE: hdl/brf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module brf_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/brf_front.sv
// Front end: takes request transfers, classifies them into commands and
// holds them in a two-entry queue for the back end. Depends on brf_pkg.
module brf_front #(
	parameter int MAX_RUN = brf_pkg::MAX_RUN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brf_pkg::req_t req,
	output logic          head_valid,
	output brf_pkg::cmd_t head,
	input  logic          pop
);

	brf_pkg::cmd_t             q_q [2];
	logic                      wp_q;
	logic                      rp_q;
	logic [1:0]                cnt_q;
	brf_pkg::cmd_t             cmd;
	logic [brf_pkg::LEN_W-1:0] len_sat;
	logic                      push;
	logic                      deq;

	assign req_ready  = (cnt_q != 2'd2);
	assign push       = req_valid && req_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_q[rp_q];
	assign deq        = pop && head_valid;

	always_comb begin
		len_sat = (req.read_length > brf_pkg::LEN_W'(MAX_RUN)) ?
			brf_pkg::LEN_W'(MAX_RUN) : req.read_length;
		cmd.data = req.data_in;
		cmd.len  = len_sat;
		case (req.req_type)
			brf_pkg::REQ_WRITE: cmd.op = brf_pkg::OP_WRITE;
			// a zero-length read behaves like a status-only request
			brf_pkg::REQ_READ:  cmd.op = (len_sat == '0) ? brf_pkg::OP_NOP : brf_pkg::OP_READ;
			brf_pkg::REQ_FLUSH: cmd.op = brf_pkg::OP_FLUSH;
			default:            cmd.op = brf_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (deq) begin
				rp_q <= ~rp_q;
			end
			case ({push, deq})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= cmd;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");

endmodule

FILE: hdl/brf_back.sv
// Back end: owns the pointers and storage RAM, executes queued commands and
// drives the result channel through an issue stage and an output register.
// Depends on brf_pkg and brf_ram.
module brf_back #(
	parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  brf_pkg::cmd_t head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brf_pkg::rsp_t rsp
);

	localparam int AW   = $clog2(DEPTH);
	localparam int PW   = AW + 1;
	localparam int CMPW = (PW > brf_pkg::LEN_W) ? PW : brf_pkg::LEN_W;

	logic [PW-1:0]              wr_ptr_q, rd_ptr_q, wr_nxt, rd_nxt;
	logic [brf_pkg::LEN_W-1:0]  run_left_q, run_nxt;
	logic [PW-1:0]              fill, fill_after;
	logic [CMPW-1:0]            len_x, fill_x, fa_x;
	logic [brf_pkg::LEN_W-1:0]  n;
	logic                       issue, can_issue, s1_adv;
	logic                       we, re, byte_rd, acc, last;
	logic [brf_pkg::DATA_W-1:0] ram_q;
	brf_pkg::rsp_t              meta_nxt;
	brf_pkg::rsp_t              meta_s1;
	logic                       valid_s1;
	logic                       rd_s1;
	brf_pkg::rsp_t              out_nxt;
	brf_pkg::rsp_t              out_q;
	logic                       out_valid_q;

	brf_ram #(
		.W(brf_pkg::DATA_W),
		.D(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_ptr_q[AW-1:0]),
		.wdata (head.data),
		.re    (re),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (ram_q)
	);

	assign fill      = wr_ptr_q - rd_ptr_q;
	assign s1_adv    = valid_s1 && (!out_valid_q || rsp_ready);
	assign can_issue = !valid_s1 || s1_adv;
	assign len_x     = CMPW'(head.len);
	assign fill_x    = CMPW'(fill);
	assign n         = (len_x < fill_x) ? head.len : fill_x[brf_pkg::LEN_W-1:0];

	always_comb begin
		issue      = 1'b0;
		pop        = 1'b0;
		we         = 1'b0;
		re         = 1'b0;
		wr_nxt     = wr_ptr_q;
		rd_nxt     = rd_ptr_q;
		run_nxt    = run_left_q;
		fill_after = fill;
		byte_rd    = 1'b0;
		acc        = 1'b0;
		last       = 1'b1;
		if (can_issue) begin
			if (run_left_q != '0) begin
				issue      = 1'b1;
				re         = 1'b1;
				byte_rd    = 1'b1;
				rd_nxt     = rd_ptr_q + PW'(1);
				fill_after = fill - PW'(1);
				last       = (run_left_q == brf_pkg::LEN_W'(1));
				run_nxt    = run_left_q - brf_pkg::LEN_W'(1);
			end else if (head_valid) begin
				issue = 1'b1;
				pop   = 1'b1;
				case (head.op)
					brf_pkg::OP_WRITE: begin
						if (fill != PW'(DEPTH)) begin
							we         = 1'b1;
							acc        = 1'b1;
							wr_nxt     = wr_ptr_q + PW'(1);
							fill_after = fill + PW'(1);
						end
					end
					brf_pkg::OP_READ: begin
						if (n != '0) begin
							re         = 1'b1;
							byte_rd    = 1'b1;
							rd_nxt     = rd_ptr_q + PW'(1);
							fill_after = fill - PW'(1);
							last       = (n == brf_pkg::LEN_W'(1));
							run_nxt    = n - brf_pkg::LEN_W'(1);
						end
					end
					brf_pkg::OP_FLUSH: begin
						wr_nxt     = '0;
						rd_nxt     = '0;
						fill_after = '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		fa_x                 = CMPW'(fill_after);
		meta_nxt.data_out    = '0;
		meta_nxt.data_valid  = byte_rd;
		meta_nxt.accepted    = acc;
		meta_nxt.last_of_run = last;
		meta_nxt.occupancy   = fa_x[brf_pkg::OCC_W-1:0];
		meta_nxt.is_empty    = (fill_after == '0);
		meta_nxt.is_full     = (fill_after == PW'(DEPTH));
	end

	always_comb begin
		out_nxt = meta_s1;
		if (rd_s1) begin
			out_nxt.data_out = ram_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			run_left_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_ptr_q   <= wr_nxt;
			rd_ptr_q   <= rd_nxt;
			run_left_q <= run_nxt;
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= meta_nxt;
			rd_s1   <= byte_rd;
		end
		if (s1_adv) begin
			out_q <= out_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= PW'(DEPTH))
		else $error("fill level above depth");

	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		(run_left_q != '0) && issue |=> run_left_q == $past(run_left_q) - brf_pkg::LEN_W'(1))
		else $error("read run count did not step");

	a_no_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(run_left_q != '0) |-> !pop && !we)
		else $error("command taken during a read run");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(meta_s1) && !$past(re))
		else $error("issue stage lost or overwritten while stalled");

endmodule

FILE: hdl/byte_ring_fifo_top.sv
// Byte ring FIFO, top level. A request passes the queue write, the issue to
// the RAM and the output register before its first result.
// Throughput: one result per cycle while rsp_ready is high; a read run gives one byte per cycle from
// the RAM's registered read port, and a write or status request gives one result each.
// Reset clears pointers, command queue and pipeline valids; storage is not cleared.
// Depends on brf_pkg, brf_front, brf_back.
module byte_ring_fifo_top #(
	parameter int DEPTH   = brf_pkg::DEPTH_DEF,
	parameter int MAX_RUN = brf_pkg::MAX_RUN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brf_pkg::rsp_t rsp
);

	logic          head_valid;
	brf_pkg::cmd_t head;
	logic          pop;

	brf_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	brf_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

FILE: sim/brf_result_check.sv
`timescale 1ns / 1ps
// Response checker for byte_ring_fifo_top: predicts every response from the
// accepted requests and compares each transfer field by field. Depends on brf_pkg.
module brf_result_check #(
	parameter int DEPTH   = brf_pkg::DEPTH_DEF,
	parameter int MAX_RUN = brf_pkg::MAX_RUN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  brf_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  brf_pkg::rsp_t rsp,
	output int            mismatches,
	output int            pending_results
);

	localparam int PTR_W = $clog2(DEPTH) + 1;

	logic [brf_pkg::DATA_W-1:0] ring_mem [DEPTH];
	logic [PTR_W-1:0]           wr_ptr;
	logic [PTR_W-1:0]           rd_ptr;
	brf_pkg::rsp_t              expected_q [$];

	function automatic brf_pkg::rsp_t with_level(brf_pkg::rsp_t e);
		logic [PTR_W-1:0] fill;
		fill = wr_ptr - rd_ptr;
		e.occupancy = brf_pkg::OCC_W'(fill);
		e.is_empty  = (fill == 0);
		e.is_full   = (fill == DEPTH);
		return e;
	endfunction

	task automatic predict_request(input brf_pkg::req_t r);
		brf_pkg::rsp_t    e;
		logic [PTR_W-1:0] lvl;
		int               fill;
		int               run_len;
		e = '0;
		e.last_of_run = 1'b1;
		lvl = wr_ptr - rd_ptr;
		fill = int'(lvl);
		case (r.req_type)
			brf_pkg::REQ_WRITE: begin
				if (fill < DEPTH) begin
					ring_mem[wr_ptr[PTR_W-2:0]] = r.data_in;
					wr_ptr = wr_ptr + 1'b1;
					e.accepted = 1'b1;
				end
				expected_q.push_back(with_level(e));
			end
			brf_pkg::REQ_READ: begin
				run_len = (int'(r.read_length) > MAX_RUN) ? MAX_RUN : int'(r.read_length);
				if (fill < run_len)
					run_len = fill;
				if (run_len == 0)
					expected_q.push_back(with_level(e));
				for (int i = 0; i < run_len; i++) begin
					e.data_out    = ring_mem[rd_ptr[PTR_W-2:0]];
					e.data_valid  = 1'b1;
					e.last_of_run = (i == run_len - 1);
					rd_ptr = rd_ptr + 1'b1;
					expected_q.push_back(with_level(e));
				end
			end
			brf_pkg::REQ_FLUSH: begin
				wr_ptr = '0;
				rd_ptr = '0;
				expected_q.push_back(with_level(e));
			end
			default: begin
				expected_q.push_back(with_level(e));
			end
		endcase
	endtask

	function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
		if (got === want)
			return 0;
		$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		brf_pkg::rsp_t want;
		if (!arst_n) begin
			expected_q.delete();
			wr_ptr = '0;
			rd_ptr = '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t ns: response transfer, expected none, got %h", $time, rsp);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					mismatches += field_diff("data_out", want.data_out, rsp.data_out)
						+ field_diff("data_valid", 8'(want.data_valid), 8'(rsp.data_valid))
						+ field_diff("accepted", 8'(want.accepted), 8'(rsp.accepted))
						+ field_diff("last_of_run", 8'(want.last_of_run),
							8'(rsp.last_of_run))
						+ field_diff("occupancy", 8'(want.occupancy), 8'(rsp.occupancy))
						+ field_diff("is_empty", 8'(want.is_empty), 8'(rsp.is_empty))
						+ field_diff("is_full", 8'(want.is_full), 8'(rsp.is_full));
				end
			end
			if (req_valid && req_ready)
				predict_request(req);
		end
		pending_results = expected_q.size();
	end

endmodule

FILE: sim/byte_ring_fifo_top_tb.sv
`timescale 1ns / 1ps
// Top of the byte ring FIFO testbench: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Depends on brf_pkg, byte_ring_fifo_top and brf_result_check.
module byte_ring_fifo_top_tb;

	localparam logic [brf_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	brf_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	brf_pkg::rsp_t rsp;

	int mismatches;
	int pending_results;
	int send_idle_pct;
	int take_idle_pct;
	int stim_items;
	int quiet_cycles = 0;

	byte_ring_fifo_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	brf_result_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= take_idle_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("byte_ring_fifo_top_tb: errors");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_request(input logic [brf_pkg::REQ_W-1:0] kind,
			input logic [brf_pkg::DATA_W-1:0] value, input logic [brf_pkg::LEN_W-1:0] len);
		brf_pkg::req_t r;
		r.req_type    = kind;
		r.data_in     = value;
		r.read_length = len;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		stim_items++;
		@(negedge clk);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
	endtask

	task automatic random_segment();
		int pick;
		int burst;
		pick = $urandom_range(99);
		if (pick < 55) begin
			burst = $urandom_range(1, 8);
			repeat (burst)
				send_request(brf_pkg::REQ_WRITE, 8'($urandom_range(255)),
					7'($urandom_range(127)));
		end else if (pick < 85) begin
			send_request(brf_pkg::REQ_READ, 8'($urandom_range(255)),
				7'(($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(127)));
		end else if (pick < 93) begin
			send_request(brf_pkg::REQ_FLUSH, 8'($urandom_range(255)),
				7'($urandom_range(127)));
		end else begin
			send_request(REQ_UNUSED, 8'($urandom_range(255)), 7'($urandom_range(127)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		stim_items    = 0;
		send_idle_pct = 10;
		take_idle_pct = 82;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty reads, zero length, unused code, writes of edge byte values
		send_request(brf_pkg::REQ_READ, 8'h00, 7'd1);
		send_request(brf_pkg::REQ_READ, 8'hFF, 7'd0);
		send_request(REQ_UNUSED, 8'hFF, 7'h7F);
		send_request(brf_pkg::REQ_WRITE, 8'h00, 7'h7F);
		send_request(brf_pkg::REQ_WRITE, 8'hFF, 7'h00);
		send_request(brf_pkg::REQ_WRITE, 8'hA5, 7'h2A);
		send_request(brf_pkg::REQ_WRITE, 8'h5A, 7'h55);
		send_request(brf_pkg::REQ_READ, 8'h00, 7'd0);
		// length saturates, run shorter than request, flush
		send_request(brf_pkg::REQ_READ, 8'h00, 7'h7F);
		send_request(brf_pkg::REQ_WRITE, 8'h01, 7'd0);
		send_request(brf_pkg::REQ_WRITE, 8'h80, 7'd0);
		send_request(brf_pkg::REQ_READ, 8'h00, 7'd1);
		send_request(brf_pkg::REQ_FLUSH, 8'hFF, 7'h7F);
		send_request(brf_pkg::REQ_READ, 8'h00, 7'd5);
		send_request(brf_pkg::REQ_FLUSH, 8'h00, 7'd0);
		send_request(brf_pkg::REQ_WRITE, 8'h7F, 7'd0);
		send_request(brf_pkg::REQ_WRITE, 8'hFE, 7'd0);
		send_request(brf_pkg::REQ_READ, 8'h00, 7'd64);
		drain_responses();

		while (stim_items < 30)
			random_segment();
		drain_responses();

		send_idle_pct = 82;
		take_idle_pct = 10;
		while (stim_items < 44)
			random_segment();
		drain_responses();

		send_idle_pct = 0;
		take_idle_pct = 0;
		// empty the ring, fill past full, then one saturated read of the whole ring
		send_request(brf_pkg::REQ_READ, 8'h00, 7'h7F);
		repeat (65)
			send_request(brf_pkg::REQ_WRITE, 8'($urandom_range(255)), 7'd0);
		send_request(brf_pkg::REQ_READ, 8'h00, 7'h7F);
		drain_responses();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results == 0)
			$display("byte_ring_fifo_top_tb: clean");
		else
			$display("byte_ring_fifo_top_tb: errors");
		$finish;
	end

endmodule
